[rtl/core/ctq_pkg.sv]
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared types and constants of the connection timeout queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 3;

    // item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;
    localparam logic [1:0] KIND_DEL   = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    // register indexes
    localparam logic REG_WAIT = 1'b0;
    localparam logic REG_KICK = 1'b1;

    // one stored timer
    typedef struct packed {
        logic [31:0] expiry;
        logic [15:0] id;
        logic [31:0] seq;
    } t_entry;

    // configuration seen by the control logic
    typedef struct packed {
        logic [15:0] wait_time;
        logic        kick;
    } t_cfg;

endpackage

[rtl/core/ctq_ram.sv]
// ----------------------------------------------------------------------------
// ctq_ram
// Timer entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ctq_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ctq_pkg::ADDR_W-1:0] i_wr_addr,
    input  ctq_pkg::t_entry            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ctq_pkg::ADDR_W-1:0] i_rd_addr,
    output ctq_pkg::t_entry            o_rd_data
);

    ctq_pkg::t_entry r_mem [ctq_pkg::QUEUE_DEPTH];
    ctq_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/ctq_cfg.sv]
// ----------------------------------------------------------------------------
// ctq_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module ctq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ctq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ctq_pkg::t_cfg               o_cfg
);

    logic [15:0] r_wait_time;
    logic        r_kick;
    logic        wr_fire;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_time <= 16'd20;
            r_kick      <= 1'b1;
        end else if (wr_fire) begin
            if (reg_sel == ctq_pkg::REG_WAIT) begin
                r_wait_time <= pwdata[15:0];
            end else begin
                r_kick <= pwdata[0];
            end
        end
    end

    // read mux
    always_comb begin
        if (reg_sel == ctq_pkg::REG_WAIT) begin
            prdata = {16'd0, r_wait_time};
        end else begin
            prdata = {31'd0, r_kick};
        end
    end

    assign o_cfg = '{wait_time: r_wait_time, kick: r_kick};

endmodule

[rtl/core/connection_timeout_queue_top.sv]
// Add shifts each entry later than the new one down a place, delete reads every
// stored entry once, clear needs no walk, poll emits each expired entry and in
// rearm mode walks it back in; one beat in, one to 64 beats out.
// Throughput: one item at a time; the entry memory's single read port sets the
// walk rate. Reset (synchronous) empties the store at once, sets wait_time to 20
// and kick_on_timeout to 1.
// ----------------------------------------------------------------------------
// connection_timeout_queue_top
// Expiry-ordered timer store kept as a circular sorted array in one memory.
// ----------------------------------------------------------------------------
module connection_timeout_queue_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [15:0]                 i_conn_id,
    input  logic [31:0]                 i_conn_seq,
    input  logic [31:0]                 i_now,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_expired_valid,
    output logic [15:0]                 o_expired_conn,
    output logic [31:0]                 o_expired_seq,
    output logic [1:0]                  o_status,
    output logic [6:0]                  o_removed_count,
    output logic [6:0]                  o_queue_count,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ctq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = ctq_pkg::ADDR_W;
    localparam int CW = ctq_pkg::CNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESP    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_CMP = 4'd3;
    localparam logic [3:0] S_P_CHK0  = 4'd4;
    localparam logic [3:0] S_P_RD    = 4'd5;
    localparam logic [3:0] S_P_CHK   = 4'd6;
    localparam logic [3:0] S_P_EMIT  = 4'd7;
    localparam logic [3:0] S_D_RD    = 4'd8;
    localparam logic [3:0] S_D_CHK   = 4'd9;

    ctq_pkg::t_cfg   cfg;
    ctq_pkg::t_entry rd_data;
    ctq_pkg::t_entry wr_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic [3:0]      r_state,   n_state;
    logic [AW-1:0]   r_head,    n_head;
    logic [CW-1:0]   r_count,   n_count;
    logic [CW-1:0]   r_idx,     n_idx;
    logic [CW-1:0]   r_wptr,    n_wptr;
    logic [CW-1:0]   r_removed, n_removed;
    logic [CW-1:0]   r_n,       n_n;
    logic [CW-1:0]   r_start,   n_start;
    logic [1:0]      r_status,  n_status;
    logic            r_last,    n_last;
    logic            r_ret_poll, n_ret_poll;
    logic [15:0]     r_id,      n_id;
    logic [31:0]     r_now,     n_now;
    logic [15:0]     r_eid,     n_eid;
    logic [31:0]     r_eseq,    n_eseq;
    ctq_pkg::t_entry r_ins,     n_ins;

    logic            r_ovalid;
    logic            r_o_xvalid;
    logic [15:0]     r_o_conn;
    logic [31:0]     r_o_seq;
    logic [1:0]      r_o_status;
    logic [CW-1:0]   r_o_removed;
    logic [CW-1:0]   r_o_count;
    logic            r_o_last;

    logic            in_fire;
    logic            out_free;
    logic            load_resp;
    logic            load_emit;

    // saturating expiry, zero wait acts as one
    function automatic logic [31:0] f_expiry(input logic [31:0] now, input logic [15:0] wt);
        logic [15:0] w;
        logic [32:0] sum;
        w   = (wt == 16'd0) ? 16'd1 : wt;
        sum = {1'b0, now} + {17'd0, w};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    ctq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ctq_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_wptr     = r_wptr;
        n_removed  = r_removed;
        n_n        = r_n;
        n_start    = r_start;
        n_status   = r_status;
        n_last     = r_last;
        n_ret_poll = r_ret_poll;
        n_id       = r_id;
        n_now      = r_now;
        n_eid      = r_eid;
        n_eseq     = r_eseq;
        n_ins      = r_ins;
        wr_en      = 1'b0;
        wr_addr    = r_head + r_idx[AW-1:0];
        wr_data    = r_ins;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        load_resp  = 1'b0;
        load_emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_id      = i_conn_id;
                    n_now     = i_now;
                    n_status  = ctq_pkg::STAT_OK;
                    n_removed = '0;
                    case (i_kind)
                        ctq_pkg::KIND_ADD: begin
                            if (r_count == CW'(ctq_pkg::QUEUE_DEPTH)) begin
                                n_status = ctq_pkg::STAT_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_ins      = '{expiry: f_expiry(i_now, cfg.wait_time),
                                               id: i_conn_id, seq: i_conn_seq};
                                n_idx      = r_count;
                                n_ret_poll = 1'b0;
                                n_state    = S_INS_RD;
                            end
                        end
                        ctq_pkg::KIND_POLL: begin
                            if (r_count == '0) begin
                                n_status = ctq_pkg::STAT_NONE;
                                n_state  = S_RESP;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = S_P_CHK0;
                            end
                        end
                        ctq_pkg::KIND_DEL: begin
                            n_idx   = '0;
                            n_wptr  = '0;
                            n_state = S_D_RD;
                        end
                        default: begin
                            n_removed = r_count;
                            n_count   = '0;
                            n_state   = S_RESP;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    load_resp = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            // walk the hole down from the tail
            S_INS_RD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_head;
                    wr_data = r_ins;
                    n_count = r_count + CW'(1);
                    n_state = r_ret_poll ? S_P_RD : S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head + r_idx[AW-1:0] - AW'(1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_head + r_idx[AW-1:0];
                if (rd_data.expiry > r_ins.expiry) begin
                    wr_data = rd_data;
                    n_idx   = r_idx - CW'(1);
                    n_state = S_INS_RD;
                end else begin
                    wr_data = r_ins;
                    n_count = r_count + CW'(1);
                    n_state = r_ret_poll ? S_P_RD : S_RESP;
                end
            end
            // poll: first head check, then pop
            S_P_CHK0: begin
                if (rd_data.expiry >= r_now) begin
                    n_status = ctq_pkg::STAT_NONE;
                    n_state  = S_RESP;
                end else begin
                    n_start = r_count;
                    n_eid   = rd_data.id;
                    n_eseq  = rd_data.seq;
                    n_head  = r_head + AW'(1);
                    n_count = r_count - CW'(1);
                    n_n     = CW'(1);
                    if (!cfg.kick) begin
                        n_ins      = '{expiry: f_expiry(r_now, cfg.wait_time),
                                       id: rd_data.id, seq: rd_data.seq};
                        n_idx      = r_count - CW'(1);
                        n_ret_poll = 1'b1;
                        n_state    = S_INS_RD;
                    end else begin
                        n_state = S_P_RD;
                    end
                end
            end
            S_P_RD: begin
                if (r_n >= r_start || r_count == '0) begin
                    n_last  = 1'b1;
                    n_state = S_P_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = S_P_CHK;
                end
            end
            S_P_CHK: begin
                n_last  = (rd_data.expiry > r_now);
                n_state = S_P_EMIT;
            end
            S_P_EMIT: begin
                if (out_free) begin
                    load_emit = 1'b1;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // head still sits in the read register
                        n_eid   = rd_data.id;
                        n_eseq  = rd_data.seq;
                        n_head  = r_head + AW'(1);
                        n_count = r_count - CW'(1);
                        n_n     = r_n + CW'(1);
                        if (!cfg.kick) begin
                            n_ins      = '{expiry: f_expiry(r_now, cfg.wait_time),
                                           id: rd_data.id, seq: rd_data.seq};
                            n_idx      = r_count - CW'(1);
                            n_ret_poll = 1'b1;
                            n_state    = S_INS_RD;
                        end else begin
                            n_state = S_P_RD;
                        end
                    end
                end
            end
            // delete: compact survivors toward the head
            S_D_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_wptr;
                    n_state = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head + r_idx[AW-1:0];
                    n_state = S_D_CHK;
                end
            end
            S_D_CHK: begin
                if (rd_data.id == r_id) begin
                    n_removed = r_removed + CW'(1);
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_head + r_wptr[AW-1:0];
                    wr_data = rd_data;
                    n_wptr  = r_wptr + CW'(1);
                end
                n_idx   = r_idx + CW'(1);
                n_state = S_D_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (load_resp || load_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_wptr     <= n_wptr;
        r_removed  <= n_removed;
        r_n        <= n_n;
        r_start    <= n_start;
        r_status   <= n_status;
        r_last     <= n_last;
        r_ret_poll <= n_ret_poll;
        r_id       <= n_id;
        r_now      <= n_now;
        r_eid      <= n_eid;
        r_eseq     <= n_eseq;
        r_ins      <= n_ins;
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (load_resp) begin
            r_o_xvalid  <= 1'b0;
            r_o_conn    <= '0;
            r_o_seq     <= '0;
            r_o_status  <= r_status;
            r_o_removed <= r_removed;
            r_o_count   <= r_count;
            r_o_last    <= 1'b1;
        end else if (load_emit) begin
            r_o_xvalid  <= 1'b1;
            r_o_conn    <= r_eid;
            r_o_seq     <= r_eseq;
            r_o_status  <= ctq_pkg::STAT_OK;
            r_o_removed <= '0;
            r_o_count   <= r_count;
            r_o_last    <= r_last;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_expired_valid = r_o_xvalid;
    assign o_expired_conn  = r_o_conn;
    assign o_expired_seq   = r_o_seq;
    assign o_status        = r_o_status;
    assign o_removed_count = r_o_removed;
    assign o_queue_count   = r_o_count;
    assign o_last          = r_o_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ctq_pkg::QUEUE_DEPTH))
        else $error("entry count above depth");

    a_ins_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_idx != '0))
        else $error("insert compare with hole at head");

    a_del_wptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D_CHK) |-> (r_wptr <= r_idx))
        else $error("delete write pointer ahead of read pointer");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("memory written while idle");

endmodule

[test/connection_timeout_queue_checker.sv]
// ----------------------------------------------------------------------------
// connection_timeout_queue_checker
// Watches the item and result channels of the timer queue, keeps its own
// copy of the sorted timer store, and compares each result beat field by
// field against the oldest expected beat.
// ----------------------------------------------------------------------------
module connection_timeout_queue_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_conn_id,
    input  logic [31:0] i_conn_seq,
    input  logic [31:0] i_now,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_expired_valid,
    input  logic [15:0] i_expired_conn,
    input  logic [31:0] i_expired_seq,
    input  logic [1:0]  i_status,
    input  logic [6:0]  i_removed_count,
    input  logic [6:0]  i_queue_count,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_sel,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        exp_valid;
        logic [15:0] conn;
        logic [31:0] seq;
        logic [1:0]  status;
        logic [6:0]  removed;
        logic [6:0]  count;
        logic        last;
    } t_beat;

    ctq_pkg::t_entry timers[$];
    t_beat           expected_beats[$];
    logic [15:0]     wait_secs;
    logic            kick;

    // saturating expiry, zero wait acts as one
    function automatic logic [31:0] expiry_at(input logic [31:0] now);
        logic [32:0] sum;
        sum = {1'b0, now} + ((wait_secs == 16'd0) ? 33'd1 : {17'd0, wait_secs});
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // sorted insert behind equal expiry times
    function automatic void arm_timer(input logic [31:0] t, input logic [15:0] id,
                                      input logic [31:0] seq);
        int pos;
        ctq_pkg::t_entry e;
        pos = 0;
        while (pos < timers.size() && timers[pos].expiry <= t) pos++;
        e.expiry = t;
        e.id = id;
        e.seq = seq;
        timers.insert(pos, e);
    endfunction

    function automatic void push_beat(input logic v, input logic [15:0] c,
                                      input logic [31:0] s, input logic [1:0] st,
                                      input int rm, input logic l);
        t_beat b;
        b.exp_valid = v;
        b.conn = c;
        b.seq = s;
        b.status = st;
        b.removed = rm[6:0];
        b.count = 7'(timers.size());
        b.last = l;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // expected beats of one accepted item
    function automatic void predict_item(input logic [1:0] kind, input logic [15:0] id,
                                         input logic [31:0] seq, input logic [31:0] now);
        int start;
        int n;
        int removed;
        int i;
        ctq_pkg::t_entry e;
        case (kind)
            ctq_pkg::KIND_ADD: begin
                if (timers.size() >= ctq_pkg::QUEUE_DEPTH) begin
                    push_beat(1'b0, 16'd0, 32'd0, ctq_pkg::STAT_FULL, 0, 1'b1);
                end else begin
                    arm_timer(expiry_at(now), id, seq);
                    push_beat(1'b0, 16'd0, 32'd0, ctq_pkg::STAT_OK, 0, 1'b1);
                end
            end
            ctq_pkg::KIND_POLL: begin
                if (timers.size() == 0 || timers[0].expiry >= now) begin
                    push_beat(1'b0, 16'd0, 32'd0, ctq_pkg::STAT_NONE, 0, 1'b1);
                end else begin
                    start = timers.size();
                    n = 0;
                    while (n < start && n < 64 && timers.size() > 0
                           && timers[0].expiry <= now) begin
                        e = timers[0];
                        timers.delete(0);
                        if (!kick) arm_timer(expiry_at(now), e.id, e.seq);
                        push_beat(1'b1, e.id, e.seq, ctq_pkg::STAT_OK, 0, 1'b0);
                        n++;
                    end
                    expected_beats[$].last = 1'b1;
                end
            end
            ctq_pkg::KIND_DEL: begin
                removed = 0;
                i = 0;
                while (i < timers.size()) begin
                    if (timers[i].id == id) begin
                        timers.delete(i);
                        removed++;
                    end else begin
                        i++;
                    end
                end
                push_beat(1'b0, 16'd0, 32'd0, ctq_pkg::STAT_OK, removed, 1'b1);
            end
            default: begin
                removed = timers.size();
                timers.delete();
                push_beat(1'b0, 16'd0, 32'd0, ctq_pkg::STAT_OK, removed, 1'b1);
            end
        endcase
    endfunction

    // compare one result beat
    task automatic check_beat();
        t_beat b;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected");
            o_fail_count++;
            return;
        end
        b = expected_beats[0];
        expected_beats.delete(0);
        if (i_expired_valid !== b.exp_valid) begin
            $error("expired_valid exp %0d got %0d", b.exp_valid, i_expired_valid);
            o_fail_count++;
        end
        if (i_expired_conn !== b.conn) begin
            $error("expired_conn exp %0d got %0d", b.conn, i_expired_conn);
            o_fail_count++;
        end
        if (i_expired_seq !== b.seq) begin
            $error("expired_seq exp %0d got %0d", b.seq, i_expired_seq);
            o_fail_count++;
        end
        if (i_status !== b.status) begin
            $error("status exp %0d got %0d", b.status, i_status);
            o_fail_count++;
        end
        if (i_removed_count !== b.removed) begin
            $error("removed_count exp %0d got %0d", b.removed, i_removed_count);
            o_fail_count++;
        end
        if (i_queue_count !== b.count) begin
            $error("queue_count exp %0d got %0d", b.count, i_queue_count);
            o_fail_count++;
        end
        if (i_last !== b.last) begin
            $error("last exp %0d got %0d", b.last, i_last);
            o_fail_count++;
        end
    endtask

    // sample both channels and the register port at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timers.delete();
            expected_beats.delete();
            o_fail_count = 0;
            wait_secs <= 16'd20;
            kick <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_sel == ctq_pkg::REG_WAIT) wait_secs <= i_cfg_data[15:0];
                else kick <= i_cfg_data[0];
            end
            if (i_in_valid && !i_in_stall) predict_item(i_kind, i_conn_id, i_conn_seq, i_now);
            if (i_out_valid && !i_out_stall) check_beat();
        end
        o_pending = expected_beats.size();
    end

endmodule

[test/connection_timeout_queue_top_tb.sv]
// ----------------------------------------------------------------------------
// connection_timeout_queue_top_tb
// Drives directed and random timer commands into the queue through several
// register settings, with random gaps and back-pressure, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module connection_timeout_queue_top_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = ctq_pkg::KIND_ADD;
    logic [15:0] conn_id = '0;
    logic [31:0] conn_seq = '0;
    logic [31:0] now = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        expired_valid;
    logic [15:0] expired_conn;
    logic [31:0] expired_seq;
    logic [1:0]  status;
    logic [6:0]  removed_count;
    logic [6:0]  queue_count;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ctq_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          out_idle_pct = 33;
    int          hold_off = 0;
    logic [31:0] clock_now = 32'd1000;

    always #1 i_clk = ~i_clk;

    connection_timeout_queue_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_conn_id(conn_id), .i_conn_seq(conn_seq), .i_now(now),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_expired_valid(expired_valid), .o_expired_conn(expired_conn),
        .o_expired_seq(expired_seq), .o_status(status),
        .o_removed_count(removed_count), .o_queue_count(queue_count), .o_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    connection_timeout_queue_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_conn_id(conn_id), .i_conn_seq(conn_seq), .i_now(now),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_expired_valid(expired_valid), .i_expired_conn(expired_conn),
        .i_expired_seq(expired_seq), .i_status(status),
        .i_removed_count(removed_count), .i_queue_count(queue_count), .i_last(last),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_sel(paddr[2]), .i_cfg_data(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("connection_timeout_queue_top_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drain results, then let a possibly silent walk finish
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // one item beat, with an optional random gap first
    task automatic send_item(input logic [1:0] k, input logic [15:0] id,
                             input logic [31:0] seq, input logic [31:0] t,
                             input int gap_pct);
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        conn_id <= id;
        conn_seq <= seq;
        now <= t;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int n, input int gap_pct);
        int r;
        logic [15:0] id;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
            clock_now = clock_now + $urandom_range(0, 15);
            if ($urandom_range(49) == 0) clock_now = $urandom;
            if (r < 50)
                send_item(ctq_pkg::KIND_ADD, id, $urandom, clock_now, gap_pct);
            else if (r < 80)
                send_item(ctq_pkg::KIND_POLL, id, $urandom,
                          clock_now + $urandom_range(0, 40), gap_pct);
            else if (r < 95)
                send_item(ctq_pkg::KIND_DEL, id, $urandom, $urandom, gap_pct);
            else
                send_item(ctq_pkg::KIND_CLEAR, id, $urandom, $urandom, gap_pct);
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, full store, overflow, absent delete
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'd5, 0);
        send_item(ctq_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(ctq_pkg::KIND_ADD, 16'd0, 32'd0, 32'd0, 0);
        send_item(ctq_pkg::KIND_ADD, 16'd1, 32'd7, 32'd0, 0);
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'd20, 0);
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'd21, 0);
        send_item(ctq_pkg::KIND_DEL, 16'd9, 32'd0, 32'd0, 0);
        send_item(ctq_pkg::KIND_DEL, 16'hFFFF, 32'd0, 32'd0, 0);
        send_item(ctq_pkg::KIND_CLEAR, 16'd0, 32'd0, 32'd0, 0);
        for (int i = 0; i < 65; i++)
            send_item(ctq_pkg::KIND_ADD, 16'(i % 3), $urandom, 32'd100, 0);
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'hFFFF_FFFF, 0);
        send_item(ctq_pkg::KIND_DEL, 16'd1, 32'd0, 32'd0, 0);
        send_item(ctq_pkg::KIND_CLEAR, 16'd0, 32'd0, 32'd0, 0);
        in_valid <= 1'b0;
        settle();

        // rearm mode, zero wait
        write_reg(ctq_pkg::REG_KICK, 32'd0);
        write_reg(ctq_pkg::REG_WAIT, 32'd0);
        for (int i = 0; i < 5; i++)
            send_item(ctq_pkg::KIND_ADD, 16'(i), $urandom, 32'd50, 0);
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'd52, 0);
        send_item(ctq_pkg::KIND_POLL, 16'd0, 32'd0, 32'd60, 0);
        send_item(ctq_pkg::KIND_ADD, 16'd9, 32'd1, 32'hFFFF_FFFF, 0);
        in_valid <= 1'b0;
        random_phase(60, 33);
        settle();

        // max wait, rearm, with the receiver held off so results back up
        write_reg(ctq_pkg::REG_WAIT, 32'd65535);
        hold_off <= 400;
        random_phase(50, 0);
        settle();

        // back to kick mode, short wait, no idling stretch
        write_reg(ctq_pkg::REG_KICK, 32'd1);
        write_reg(ctq_pkg::REG_WAIT, 32'd3);
        out_idle_pct = 0;
        random_phase(40, 0);
        out_idle_pct = 33;
        random_phase(40, 33);
        settle();

        write_reg(ctq_pkg::REG_WAIT, 32'd1);
        random_phase(30, 33);
        settle();

        if (fail_count == 0)
            $display("connection_timeout_queue_top_tb OK");
        else
            $display("connection_timeout_queue_top_tb NOT OK");
        $finish;
    end

endmodule
